// ===== rtl/rasr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rasr_pkg
// shared types and constants for the rational add/subtract/reduce block
// ----------------------------------------------------------------------------
package rasr_pkg;

   localparam int OPERAND_WIDTH_DEF = 32;
   localparam int RES_NUM_WIDTH     = 64;
   localparam int RES_DEN_WIDTH     = 62;
   localparam int SHIFT_WIDTH       = 6;
   localparam int DIV_COUNT_WIDTH   = 6;

   localparam logic OPCODE_ADD = 1'b0;
   localparam logic OPCODE_SUB = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_P1,
      OP_MUL_P2,
      OP_MUL_DEN,
      OP_SUM,
      OP_GCD_PAIR,
      OP_GCD_SHIFT_X,
      OP_GCD_STEP,
      OP_GCD_END,
      OP_DIV_STEP,
      OP_DIV_SWAP,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      logic den_zero;
      logic mag_zero;
      logic both_even;
      logic x_even;
      logic y_zero;
   } dp_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_P1,
      S_MUL_P2,
      S_MUL_DEN,
      S_SUM,
      S_CHECK,
      S_GCD_PAIR,
      S_GCD_X,
      S_GCD_LOOP,
      S_GCD_END,
      S_DIV_MAG,
      S_DIV_SWAP,
      S_DIV_DEN,
      S_FINISH
   } state_type;

endpackage
`default_nettype wire

// ===== rtl/rasr_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rasr_datapath
// operand registers, shared multiplier, binary gcd and shared restoring divider
// ----------------------------------------------------------------------------
module rasr_datapath import rasr_pkg::*; #(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  wire                              clock,
   input  dp_op_type                        dp_op,
   output dp_status_type                    dp_status,
   input  wire                              req_opcode,
   input  wire signed [OPERAND_WIDTH-1:0]   req_num_a,
   input  wire        [OPERAND_WIDTH-2:0]   req_den_a,
   input  wire signed [OPERAND_WIDTH-1:0]   req_num_b,
   input  wire        [OPERAND_WIDTH-2:0]   req_den_b,
   output logic signed [RES_NUM_WIDTH-1:0]  rsp_res_num,
   output logic        [RES_DEN_WIDTH-1:0]  rsp_res_den
);

   localparam int NW = OPERAND_WIDTH;
   localparam int DW = OPERAND_WIDTH - 1;
   localparam int PW = 2 * OPERAND_WIDTH;
   localparam int RW = RES_NUM_WIDTH;

   logic                  opcode_ff;
   logic signed [NW-1:0]  num_a_ff, num_b_ff;
   logic        [DW-1:0]  den_a_ff, den_b_ff;
   logic        [RW-1:0]  p1_ff, p2_ff, den_ff;
   logic        [RW-1:0]  mag_ff, x_ff, y_ff, g_ff;
   logic                  neg_ff;
   logic [SHIFT_WIDTH-1:0] sh_ff;
   logic        [RW-1:0]  div_rem_ff, div_quo_ff, quo_mag_ff;
   logic signed [RES_NUM_WIDTH-1:0] res_num_ff;
   logic        [RES_DEN_WIDTH-1:0] res_den_ff;

   logic signed [NW-1:0]  mul_a;
   logic        [DW-1:0]  mul_b;
   logic signed [PW-1:0]  mul_p;
   logic signed [RW-1:0]  mul_ext;
   logic        [RW-1:0]  sum;
   logic        [RW-1:0]  sum_mag;
   logic        [RW:0]    y_minus_x;
   logic        [RW-1:0]  x_minus_y;
   logic        [RW:0]    rem_sh;
   logic                  rem_ge;
   logic        [RW:0]    rem_sub;

   // one shared multiplier; the denominator product uses the same signed unit
   always_comb begin
      unique case (dp_op)
         OP_MUL_P1: begin
            mul_a = num_a_ff;
            mul_b = den_b_ff;
         end
         OP_MUL_P2: begin
            mul_a = num_b_ff;
            mul_b = den_a_ff;
         end
         default: begin
            mul_a = $signed({1'b0, den_a_ff});
            mul_b = den_b_ff;
         end
      endcase
   end

   assign mul_p   = PW'(mul_a) * PW'($signed({1'b0, mul_b}));
   assign mul_ext = RW'(mul_p);

   assign sum     = (opcode_ff == OPCODE_SUB) ? (p1_ff - p2_ff) : (p1_ff + p2_ff);
   assign sum_mag = sum[RW-1] ? (RW'(0) - sum) : sum;

   assign y_minus_x = {1'b0, y_ff} - {1'b0, x_ff};
   assign x_minus_y = x_ff - y_ff;

   // restoring division, one quotient bit per cycle
   assign rem_sh  = {div_rem_ff, div_quo_ff[RW-1]};
   assign rem_ge  = rem_sh >= {1'b0, g_ff};
   assign rem_sub = rem_sh - {1'b0, g_ff};

   always_ff @(posedge clock) begin
      unique case (dp_op)
         OP_LOAD: begin
            opcode_ff <= req_opcode;
            num_a_ff  <= req_num_a;
            den_a_ff  <= req_den_a;
            num_b_ff  <= req_num_b;
            den_b_ff  <= req_den_b;
         end
         OP_MUL_P1:  p1_ff  <= mul_ext;
         OP_MUL_P2:  p2_ff  <= mul_ext;
         OP_MUL_DEN: den_ff <= mul_ext;
         OP_SUM: begin
            mag_ff <= sum_mag;
            neg_ff <= sum[RW-1];
            x_ff   <= sum_mag;
            y_ff   <= den_ff;
            sh_ff  <= '0;
         end
         OP_GCD_PAIR: begin
            x_ff  <= x_ff >> 1;
            y_ff  <= y_ff >> 1;
            sh_ff <= sh_ff + SHIFT_WIDTH'(1);
         end
         OP_GCD_SHIFT_X: x_ff <= x_ff >> 1;
         OP_GCD_STEP: begin
            if (!y_ff[0]) begin
               y_ff <= y_ff >> 1;
            end else if (y_minus_x[RW]) begin
               // x larger: swap and subtract
               x_ff <= y_ff;
               y_ff <= x_minus_y;
            end else begin
               y_ff <= y_minus_x[RW-1:0];
            end
         end
         OP_GCD_END: begin
            g_ff       <= x_ff << sh_ff;
            div_rem_ff <= '0;
            div_quo_ff <= mag_ff;
         end
         OP_DIV_STEP: begin
            div_rem_ff <= rem_ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
            div_quo_ff <= {div_quo_ff[RW-2:0], rem_ge};
         end
         OP_DIV_SWAP: begin
            quo_mag_ff <= div_quo_ff;
            div_rem_ff <= '0;
            div_quo_ff <= den_ff;
         end
         OP_OUT: begin
            if (dp_status.den_zero) begin
               res_num_ff <= '0;
               res_den_ff <= '0;
            end else if (dp_status.mag_zero) begin
               res_num_ff <= '0;
               res_den_ff <= RES_DEN_WIDTH'(1);
            end else begin
               res_num_ff <= neg_ff ? $signed(RW'(0) - quo_mag_ff) : $signed(quo_mag_ff);
               res_den_ff <= div_quo_ff[RES_DEN_WIDTH-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   assign dp_status.den_zero  = (den_a_ff == '0) || (den_b_ff == '0);
   assign dp_status.mag_zero  = (mag_ff == '0);
   assign dp_status.both_even = !x_ff[0] && !y_ff[0];
   assign dp_status.x_even    = !x_ff[0];
   assign dp_status.y_zero    = (y_ff == '0);

   assign rsp_res_num = res_num_ff;
   assign rsp_res_den = res_den_ff;

endmodule
`default_nettype wire

// ===== rtl/rasr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rasr_ctrl
// sequencer for multiply, gcd and division steps plus the result handshake
// ----------------------------------------------------------------------------
module rasr_ctrl import rasr_pkg::*; (
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  wire           rsp_stall,
   input  dp_status_type dp_status,
   output dp_op_type     dp_op
);

   state_type                  state_ff, state_in;
   logic [DIV_COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dp_op        = OP_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_op    = OP_LOAD;
               state_in = S_MUL_P1;
            end
         end
         S_MUL_P1: begin
            dp_op    = OP_MUL_P1;
            state_in = S_MUL_P2;
         end
         S_MUL_P2: begin
            dp_op    = OP_MUL_P2;
            state_in = S_MUL_DEN;
         end
         S_MUL_DEN: begin
            dp_op    = OP_MUL_DEN;
            state_in = S_SUM;
         end
         S_SUM: begin
            dp_op    = OP_SUM;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // zero denominator and zero result skip the reduction
            if (dp_status.den_zero || dp_status.mag_zero) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_GCD_PAIR;
            end
         end
         S_GCD_PAIR: begin
            if (dp_status.both_even) begin
               dp_op = OP_GCD_PAIR;
            end else begin
               state_in = S_GCD_X;
            end
         end
         S_GCD_X: begin
            if (dp_status.x_even) begin
               dp_op = OP_GCD_SHIFT_X;
            end else begin
               state_in = S_GCD_LOOP;
            end
         end
         S_GCD_LOOP: begin
            if (dp_status.y_zero) begin
               state_in = S_GCD_END;
            end else begin
               dp_op = OP_GCD_STEP;
            end
         end
         S_GCD_END: begin
            dp_op    = OP_GCD_END;
            cnt_in   = '0;
            state_in = S_DIV_MAG;
         end
         S_DIV_MAG: begin
            dp_op  = OP_DIV_STEP;
            cnt_in = cnt_ff + DIV_COUNT_WIDTH'(1);
            if (&cnt_ff) begin
               state_in = S_DIV_SWAP;
            end
         end
         S_DIV_SWAP: begin
            dp_op    = OP_DIV_SWAP;
            cnt_in   = '0;
            state_in = S_DIV_DEN;
         end
         S_DIV_DEN: begin
            dp_op  = OP_DIV_STEP;
            cnt_in = cnt_ff + DIV_COUNT_WIDTH'(1);
            if (&cnt_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // wait here only while the previous transaction is still unread
            if (out_free) begin
               dp_op        = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/rational_add_sub_reduce.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rational_add_sub_reduce
// exact add or subtract of two signed fractions, reduced to lowest terms
// ----------------------------------------------------------------------------
// Takes num_a/den_a and num_b/den_b (positive denominators) and returns
// (num_a*den_b +/- num_b*den_a) / (den_a*den_b) divided through by the gcd of
// the magnitude of the numerator and the denominator. A zero result comes back
// as 0/1; a zero input denominator comes back as 0/0. One transaction is worked
// on at a time: cross multiply and sum through the single shared multiplier,
// a binary gcd that moves one shift or one subtract per cycle, then two passes
// of the shared restoring divider; the zero cases skip the gcd and the divider.
// A new request is taken while the last result still waits on rsp_stall.
module rational_add_sub_reduce import rasr_pkg::*; #(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire                              req_opcode,
   input  wire signed [OPERAND_WIDTH-1:0]   req_num_a,
   input  wire        [OPERAND_WIDTH-2:0]   req_den_a,
   input  wire signed [OPERAND_WIDTH-1:0]   req_num_b,
   input  wire        [OPERAND_WIDTH-2:0]   req_den_b,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic signed [RES_NUM_WIDTH-1:0]  rsp_res_num,
   output logic        [RES_DEN_WIDTH-1:0]  rsp_res_den
);

   dp_op_type     dp_op;
   dp_status_type dp_status;

   rasr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .dp_op     (dp_op)
   );

   rasr_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .dp_op       (dp_op),
      .dp_status   (dp_status),
      .req_opcode  (req_opcode),
      .req_num_a   (req_num_a),
      .req_den_a   (req_den_a),
      .req_num_b   (req_num_b),
      .req_den_b   (req_den_b),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den)
   );

endmodule
`default_nettype wire
